FILE: src/nbs_pkg.sv
// ----------------------------------------------------------------------------
// nbs_pkg
// shared types, codes and fixed-point constants of the n-body step core
// ----------------------------------------------------------------------------
package nbs_pkg;

  // fractional bits of positions and velocities, and of the time step
  localparam int FRAC_BITS   = 24;
  localparam int DT_BITS     = 24;
  localparam int RSQRT_ITERS = 5;

  // acceleration clamp, 2^56
  localparam logic [63:0] ACC_LIMIT = 64'h0100_0000_0000_0000;

  // reciprocal square root seeds and constants, unsigned q2.30
  localparam logic [31:0] SEED_HI   = 32'd1288490189;
  localparam logic [31:0] SEED_LO   = 32'd1825361101;
  localparam logic [33:0] THREE_Q30 = 34'h0_C000_0000;
  localparam logic [31:0] Y_MAX     = 32'h8000_0000;

  typedef enum logic [1:0] {
    ACT_LOAD,
    ACT_STEP,
    ACT_READ,
    ACT_NONE
  } action_e;

  typedef enum logic [1:0] {
    KIND_LOAD_ACK,
    KIND_STEP_DONE,
    KIND_DATA
  } kind_e;

  typedef enum logic [1:0] {
    CFG_COUNT,
    CFG_DT,
    CFG_SOFT
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [9:0]         index;
    logic signed [31:0] in_pos_x;
    logic signed [31:0] in_pos_y;
    logic signed [31:0] in_pos_z;
    logic signed [31:0] in_vel_x;
    logic signed [31:0] in_vel_y;
    logic signed [31:0] in_vel_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         out_index;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
    logic               saturated;
  } out_item_t;

  // one store word: element 0 is x, 1 is y, 2 is z
  typedef logic [2:0][31:0] vec3_t;

  typedef enum logic [5:0] {
    S_IDLE, S_READ,
    S_PI, S_PI_W, S_PJ, S_D,
    S_SQ_MUL, S_SQ_ADD, S_SOFT, S_NORM, S_SEED,
    S_R_YY, S_R_Y2, S_R_AY, S_R_T, S_R_YT, S_R_YU,
    S_Y_YY, S_Y_Y2, S_Y_MUL, S_Y3,
    S_TM_MUL, S_TM_SH, S_TM_ACC,
    S_VRD, S_VRD_W,
    S_DT_MAG, S_DT_HI, S_DT_LO, S_DT_SUM, S_DT_UPD,
    S_VWR, S_P2_RD, S_P2_W, S_PWR, S_DONE
  } state_e;

endpackage

FILE: src/nbody_gravity_step_core.sv
// ----------------------------------------------------------------------------
// nbody_gravity_step_core
// direct-sum gravity with one euler step over particles held in two memories
// ----------------------------------------------------------------------------
// load: answer registered as the beat is accepted; read: both memories are
//   addressed on acceptance, then S_READ registers the answer from the read data
// step: pace set by the single shared 33x33 multiplier that runs every pair's
//   squares, five newton iterations and three force terms
// one item at a time; reset clears control, config returns to its reset values,
//   particle memories are not cleared and hold garbage until loaded
module nbody_gravity_step_core #(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  nbs_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output nbs_pkg::out_item_t   out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  import nbs_pkg::*;

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int CW = AW + 1;

  localparam logic signed [58:0] ACC_POS = 59'sh0100_0000_0000_0000;
  localparam logic signed [58:0] ACC_NEG = -ACC_POS;
  localparam logic signed [59:0] S32_MAX = 60'sd2147483647;
  localparam logic signed [59:0] S32_MIN = -60'sd2147483648;

  // control and config state
  state_e      state_q, state_d;
  logic [10:0] count_q;
  logic [23:0] dt_q;
  logic [31:0] soft_q;
  logic        sat_q, sat_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  // sequencer counters
  logic [9:0]    idx_q, idx_d;
  logic [CW-1:0] n_q, n_d, i_q, i_d, j_q, j_d;
  logic [1:0]    ax_q, ax_d;
  logic [2:0]    k_q, k_d;
  logic [2:0]    norm_q, norm_d;
  logic          phase2_q, phase2_d;

  // datapath registers
  vec3_t              pi_q, pi_d;
  vec3_t              vreg_q, vreg_d;
  vec3_t              res_q, res_d;
  logic [32:0]        dmag_q [3];
  logic [32:0]        dmag_d [3];
  logic [2:0]         dneg_q, dneg_d;
  logic [63:0]        d2_q, d2_d;
  logic [5:0]         s_q, s_d;
  logic signed [7:0]  sh_q, sh_d;
  logic [31:0]        y_q, y_d;
  logic [31:0]        y3_q, y3_d;
  logic [57:0]        tmp_q, tmp_d;
  logic signed [57:0] acc_q [3];
  logic signed [57:0] acc_d [3];
  logic [56:0]        mag_q, mag_d;
  logic               neg_q, neg_d;

  // memory and multiplier ports
  logic          pos_we, vel_we;
  logic [AW-1:0] waddr, raddr;
  vec3_t         pos_wdata, vel_wdata, pos_rdata, vel_rdata;
  logic [32:0]   mul_a, mul_b;
  logic [65:0]   prod;

  // handshake
  logic in_acc, out_free, idx_ok;
  logic [CW-1:0] n_in;
  action_e act;

  assign act      = action_e'(in_data_i.action);
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) | ~out_free;
  assign in_acc   = in_valid_i & ~in_stall_o;
  assign idx_ok   = 32'(in_data_i.index) < MAX_PARTICLES;
  assign n_in     = (32'(count_q) > MAX_PARTICLES) ? CW'(MAX_PARTICLES) : CW'(count_q);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  nbs_ram #(.W(96), .DEPTH(MAX_PARTICLES), .AW(AW)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (waddr),
    .wdata_i (pos_wdata),
    .raddr_i (raddr),
    .rdata_o (pos_rdata)
  );

  nbs_ram #(.W(96), .DEPTH(MAX_PARTICLES), .AW(AW)) u_vel_ram (
    .clk_i   (clk_i),
    .we_i    (vel_we),
    .waddr_i (waddr),
    .wdata_i (vel_wdata),
    .raddr_i (raddr),
    .rdata_o (vel_rdata)
  );

  nbs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // ---------------------------------------------------------------------------
  // arithmetic helpers
  // ---------------------------------------------------------------------------

  // saturating 64-bit add for the squared distance
  logic [63:0] add_b, sat_sum;
  logic [64:0] sum65;
  assign add_b   = (state_q == S_SOFT) ? 64'(soft_q) : prod[63:0];
  assign sum65   = {1'b0, d2_q} + {1'b0, add_b};
  assign sat_sum = sum65[64] ? '1 : sum65[63:0];

  // normalisation: binary search in even steps, largest first
  logic [6:0] norm_amt;
  logic       norm_top0;
  always_comb begin
    case (norm_q)
      3'd0:    norm_amt = 7'd32;
      3'd1:    norm_amt = 7'd16;
      3'd2:    norm_amt = 7'd8;
      3'd3:    norm_amt = 7'd4;
      default: norm_amt = 7'd2;
    endcase
  end
  assign norm_top0 = ((d2_q >> (7'd64 - norm_amt)) == 64'd0);

  // newton step pieces
  logic [33:0] ay2;
  logic [31:0] r_t;
  logic [34:0] yn;
  logic [31:0] y_new;
  assign ay2   = prod[65:32];
  assign r_t   = (ay2 >= THREE_Q30) ? 32'd0 : 32'(THREE_Q30 - ay2);
  assign yn    = prod[65:31];
  assign y_new = (yn > 35'(Y_MAX)) ? Y_MAX : yn[31:0];

  // pair term shift and clamp
  logic [63:0] tm_p, tm_sh, tm_lim;
  logic [6:0]  tm_nl;
  logic        tm_ovf;
  logic [7:0]  sh_neg;
  assign tm_p   = prod[63:0];
  assign sh_neg = 8'(-sh_q);
  assign tm_nl  = sh_neg[6:0];
  assign tm_lim = ACC_LIMIT >> tm_nl;
  always_comb begin
    tm_ovf = 1'b0;
    if (sh_q >= 8'sd63) begin
      tm_sh = 64'd0;
    end else if (sh_q >= 8'sd0) begin
      tm_sh = tm_p >> sh_q[5:0];
    end else if (tm_p > tm_lim) begin
      tm_sh  = ACC_LIMIT;
      tm_ovf = 1'b1;
    end else begin
      tm_sh = tm_p << tm_nl;
    end
    if (tm_sh > ACC_LIMIT) begin
      tm_sh  = ACC_LIMIT;
      tm_ovf = 1'b1;
    end
  end

  // running sum update with clamp
  logic signed [57:0] acc_cur;
  logic signed [58:0] acc_sum;
  logic signed [57:0] acc_new;
  logic               acc_ovf;
  assign acc_cur = acc_q[ax_q];
  always_comb begin
    if (dneg_q[ax_q]) begin
      acc_sum = {acc_cur[57], acc_cur} - {2'b00, tmp_q[56:0]};
    end else begin
      acc_sum = {acc_cur[57], acc_cur} + {2'b00, tmp_q[56:0]};
    end
    acc_ovf = 1'b0;
    if (acc_sum > ACC_POS) begin
      acc_new = 58'(ACC_POS);
      acc_ovf = 1'b1;
    end else if (acc_sum < ACC_NEG) begin
      acc_new = 58'(ACC_NEG);
      acc_ovf = 1'b1;
    end else begin
      acc_new = 58'(acc_sum);
    end
  end

  // dt product: source is the sum in the velocity pass, the velocity in the position pass
  logic [57:0]        src_w;
  logic [31:0]        base_w;
  logic signed [59:0] upd_sum;
  logic [31:0]        upd_new;
  logic               upd_ovf;
  assign src_w  = phase2_q ? {{26{vreg_q[ax_q][31]}}, vreg_q[ax_q]} : acc_q[ax_q];
  assign base_w = phase2_q ? pi_q[ax_q] : vreg_q[ax_q];
  always_comb begin
    if (neg_q) begin
      upd_sum = {{28{base_w[31]}}, base_w} - {2'b00, tmp_q};
    end else begin
      upd_sum = {{28{base_w[31]}}, base_w} + {2'b00, tmp_q};
    end
    upd_ovf = 1'b0;
    if (upd_sum > S32_MAX) begin
      upd_new = 32'h7FFF_FFFF;
      upd_ovf = 1'b1;
    end else if (upd_sum < S32_MIN) begin
      upd_new = 32'h8000_0000;
      upd_ovf = 1'b1;
    end else begin
      upd_new = upd_sum[31:0];
    end
  end

  logic last_ax, last_i;
  assign last_ax = (ax_q == 2'd2);
  assign last_i  = ((i_q + CW'(1)) == n_q);

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (act == ACT_READ && idx_ok) begin
            state_d = S_READ;
          end else if (act == ACT_STEP && n_in != '0) begin
            state_d = S_PI;
          end
        end
      end
      S_READ:   state_d = S_IDLE;
      S_PI:     state_d = S_PI_W;
      S_PI_W:   state_d = S_PJ;
      S_PJ: begin
        if (j_q == n_q) begin
          state_d = S_VRD;
        end else if (j_q != i_q) begin
          state_d = S_D;
        end
      end
      S_D:      state_d = S_SQ_MUL;
      S_SQ_MUL: state_d = S_SQ_ADD;
      S_SQ_ADD: state_d = last_ax ? S_SOFT : S_SQ_MUL;
      S_SOFT:   state_d = (sat_sum == 64'd0) ? S_PJ : S_NORM;
      S_NORM:   state_d = (norm_q == 3'd4) ? S_SEED : S_NORM;
      S_SEED:   state_d = S_R_YY;
      S_R_YY:   state_d = S_R_Y2;
      S_R_Y2:   state_d = S_R_AY;
      S_R_AY:   state_d = S_R_T;
      S_R_T:    state_d = S_R_YT;
      S_R_YT:   state_d = S_R_YU;
      S_R_YU:   state_d = (k_q == 3'(RSQRT_ITERS - 1)) ? S_Y_YY : S_R_YY;
      S_Y_YY:   state_d = S_Y_Y2;
      S_Y_Y2:   state_d = S_Y_MUL;
      S_Y_MUL:  state_d = S_Y3;
      S_Y3:     state_d = S_TM_MUL;
      S_TM_MUL: state_d = S_TM_SH;
      S_TM_SH:  state_d = S_TM_ACC;
      S_TM_ACC: state_d = last_ax ? S_PJ : S_TM_MUL;
      S_VRD:    state_d = S_VRD_W;
      S_VRD_W:  state_d = S_DT_MAG;
      S_DT_MAG: state_d = S_DT_HI;
      S_DT_HI:  state_d = S_DT_LO;
      S_DT_LO:  state_d = S_DT_SUM;
      S_DT_SUM: state_d = S_DT_UPD;
      S_DT_UPD: begin
        if (!last_ax) begin
          state_d = S_DT_MAG;
        end else begin
          state_d = phase2_q ? S_PWR : S_VWR;
        end
      end
      S_VWR:    state_d = last_i ? S_P2_RD : S_PI;
      S_P2_RD:  state_d = S_P2_W;
      S_P2_W:   state_d = S_DT_MAG;
      S_PWR:    state_d = last_i ? S_DONE : S_P2_RD;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // memory and multiplier control
  // ---------------------------------------------------------------------------
  always_comb begin
    pos_we    = 1'b0;
    vel_we    = 1'b0;
    waddr     = i_q[AW-1:0];
    raddr     = i_q[AW-1:0];
    pos_wdata = res_q;
    vel_wdata = res_q;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      S_IDLE: begin
        waddr     = AW'(in_data_i.index);
        raddr     = AW'(in_data_i.index);
        pos_wdata = {in_data_i.in_pos_z, in_data_i.in_pos_y, in_data_i.in_pos_x};
        vel_wdata = {in_data_i.in_vel_z, in_data_i.in_vel_y, in_data_i.in_vel_x};
        if (in_acc && act == ACT_LOAD && idx_ok) begin
          pos_we = 1'b1;
          vel_we = 1'b1;
        end
      end
      S_PJ:     raddr = j_q[AW-1:0];
      S_SQ_MUL: begin
        mul_a = dmag_q[ax_q];
        mul_b = dmag_q[ax_q];
      end
      S_R_YY, S_Y_YY: begin
        mul_a = {1'b0, y_q};
        mul_b = {1'b0, y_q};
      end
      S_R_AY: begin
        mul_a = {1'b0, d2_q[63:32]};
        mul_b = tmp_q[32:0];
      end
      S_R_YT, S_Y_MUL: begin
        mul_a = {1'b0, y_q};
        mul_b = tmp_q[32:0];
      end
      S_TM_MUL: begin
        mul_a = dmag_q[ax_q];
        mul_b = {1'b0, y3_q};
      end
      S_DT_HI: begin
        mul_a = mag_q[56:24];
        mul_b = 33'(dt_q);
      end
      S_DT_LO: begin
        mul_a = 33'(mag_q[23:0]);
        mul_b = 33'(dt_q);
      end
      S_VWR:    vel_we = 1'b1;
      S_PWR:    pos_we = 1'b1;
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath and result register
  // ---------------------------------------------------------------------------
  always_comb begin
    sat_d       = sat_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    idx_d       = idx_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    ax_d        = ax_q;
    k_d         = k_q;
    norm_d      = norm_q;
    phase2_d    = phase2_q;
    pi_d        = pi_q;
    vreg_d      = vreg_q;
    res_d       = res_q;
    dmag_d      = dmag_q;
    dneg_d      = dneg_q;
    d2_d        = d2_q;
    s_d         = s_q;
    sh_d        = sh_q;
    y_d         = y_q;
    y3_d        = y3_q;
    tmp_d       = tmp_q;
    acc_d       = acc_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_d           = '0;
          out_d.out_index = in_data_i.index;
          out_d.saturated = sat_q;
          idx_d           = in_data_i.index;
          case (act)
            ACT_LOAD: begin
              out_d.kind  = KIND_LOAD_ACK;
              out_valid_d = 1'b1;
            end
            ACT_STEP: begin
              sat_d           = 1'b0;
              n_d             = n_in;
              i_d             = '0;
              out_d.kind      = KIND_STEP_DONE;
              out_d.out_index = '0;
              out_d.saturated = 1'b0;
              // empty step answers at once
              out_valid_d     = (n_in == '0);
            end
            ACT_READ: begin
              out_d.kind  = KIND_DATA;
              // slot beyond the store answers zero data straight away
              out_valid_d = ~idx_ok;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        out_d.kind      = KIND_DATA;
        out_d.out_index = idx_q;
        out_d.out_pos_x = pos_rdata[0];
        out_d.out_pos_y = pos_rdata[1];
        out_d.out_pos_z = pos_rdata[2];
        out_d.out_vel_x = vel_rdata[0];
        out_d.out_vel_y = vel_rdata[1];
        out_d.out_vel_z = vel_rdata[2];
        out_d.saturated = sat_q;
        out_valid_d     = 1'b1;
      end
      S_PI_W: begin
        pi_d = pos_rdata;
        j_d  = '0;
        for (int a = 0; a < 3; a++) begin
          acc_d[a] = '0;
        end
      end
      S_PJ: begin
        // own slot takes no part
        if (j_q != n_q && j_q == i_q) begin
          j_d = j_q + CW'(1);
        end
      end
      S_D: begin
        for (int a = 0; a < 3; a++) begin
          if ($signed(pos_rdata[a]) < $signed(pi_q[a])) begin
            dmag_d[a] = {pi_q[a][31], pi_q[a]} - {pos_rdata[a][31], pos_rdata[a]};
            dneg_d[a] = 1'b1;
          end else begin
            dmag_d[a] = {pos_rdata[a][31], pos_rdata[a]} - {pi_q[a][31], pi_q[a]};
            dneg_d[a] = 1'b0;
          end
        end
        d2_d = '0;
        ax_d = '0;
      end
      S_SQ_ADD: begin
        d2_d = sat_sum;
        if (sum65[64]) begin
          sat_d = 1'b1;
        end
        ax_d = last_ax ? 2'd0 : ax_q + 2'd1;
      end
      S_SOFT: begin
        d2_d   = sat_sum;
        s_d    = '0;
        norm_d = '0;
        if (sum65[64]) begin
          sat_d = 1'b1;
        end
        // coincident pair with no softening contributes nothing
        if (sat_sum == 64'd0) begin
          j_d = j_q + CW'(1);
        end
      end
      S_NORM: begin
        if (norm_top0) begin
          d2_d = d2_q << norm_amt;
          s_d  = s_q + norm_amt[5:0];
        end
        norm_d = norm_q + 3'd1;
      end
      S_SEED: begin
        y_d  = d2_q[63] ? SEED_HI : SEED_LO;
        k_d  = '0;
        sh_d = 8'(28 + 3 * (32 - int'(s_q >> 1) - FRAC_BITS));
      end
      S_R_Y2, S_Y_Y2: tmp_d = 58'(prod[62:30]);
      S_R_T:          tmp_d = 58'(r_t);
      S_R_YU: begin
        y_d = y_new;
        k_d = k_q + 3'd1;
      end
      S_Y3: begin
        y3_d = prod[63:32];
        ax_d = '0;
      end
      S_TM_SH: begin
        tmp_d = 58'(tm_sh[56:0]);
        if (tm_ovf) begin
          sat_d = 1'b1;
        end
      end
      S_TM_ACC: begin
        acc_d[ax_q] = acc_new;
        if (acc_ovf) begin
          sat_d = 1'b1;
        end
        if (last_ax) begin
          ax_d = '0;
          j_d  = j_q + CW'(1);
        end else begin
          ax_d = ax_q + 2'd1;
        end
      end
      S_VRD_W: begin
        vreg_d   = vel_rdata;
        ax_d     = '0;
        phase2_d = 1'b0;
      end
      S_DT_MAG: begin
        neg_d = src_w[57];
        mag_d = src_w[57] ? 57'(~src_w + 58'd1) : src_w[56:0];
      end
      S_DT_LO:  tmp_d = prod[57:0];
      S_DT_SUM: tmp_d = tmp_q + 58'(prod[47:24]);
      S_DT_UPD: begin
        res_d[ax_q] = upd_new;
        if (upd_ovf) begin
          sat_d = 1'b1;
        end
        ax_d = last_ax ? 2'd0 : ax_q + 2'd1;
      end
      S_VWR: i_d = last_i ? '0 : i_q + CW'(1);
      S_P2_W: begin
        pi_d     = pos_rdata;
        vreg_d   = vel_rdata;
        ax_d     = '0;
        phase2_d = 1'b1;
      end
      S_PWR: i_d = i_q + CW'(1);
      S_DONE: begin
        out_d           = '0;
        out_d.kind      = KIND_STEP_DONE;
        out_d.saturated = sat_q;
        out_valid_d     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= 11'd1024;
      dt_q        <= 24'd8389;
      soft_q      <= 32'd1;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      ax_q        <= '0;
      k_q         <= '0;
      norm_q      <= '0;
      phase2_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      i_q         <= i_d;
      j_q         <= j_d;
      ax_q        <= ax_d;
      k_q         <= k_d;
      norm_q      <= norm_d;
      phase2_q    <= phase2_d;
      // register writes are taken whenever they come
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_COUNT: count_q <= cfg_data_i[10:0];
          CFG_DT:    dt_q    <= cfg_data_i[23:0];
          CFG_SOFT:  soft_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    idx_q  <= idx_d;
    pi_q   <= pi_d;
    vreg_q <= vreg_d;
    res_q  <= res_d;
    dmag_q <= dmag_d;
    dneg_q <= dneg_d;
    d2_q   <= d2_d;
    s_q    <= s_d;
    sh_q   <= sh_d;
    y_q    <= y_d;
    y3_q   <= y3_d;
    tmp_q  <= tmp_d;
    acc_q  <= acc_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
  end

endmodule

FILE: src/nbs_ram.sv
// ----------------------------------------------------------------------------
// nbs_ram
// simple dual-port synchronous memory, registered read data
// ----------------------------------------------------------------------------
module nbs_ram #(
  parameter int W     = 96,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: src/nbs_mul.sv
// ----------------------------------------------------------------------------
// nbs_mul
// shared unsigned 33x33 multiplier with registered product
// ----------------------------------------------------------------------------
module nbs_mul (
  input  logic        clk_i,
  input  logic [32:0] a_i,
  input  logic [32:0] b_i,
  output logic [65:0] p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= 66'(a_i) * 66'(b_i);
  end

endmodule

FILE: verif/tb_nbody_gravity_step_core.sv
// ----------------------------------------------------------------------------
// tb_nbody_gravity_step_core
// self-checking bench: loads, reads and euler steps against an in-bench
// fixed-point gravity predictor, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module tb_nbody_gravity_step_core;
  import nbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SLOTS = 1024;
  localparam int SETTLE    = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_COUNT;
  logic [31:0] cfg_data_i = '0;

  nbody_gravity_step_core u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // particle model state and its copy of the registers
  int         pos_m [3][MAX_SLOTS];
  int         vel_m [3][MAX_SLOTS];
  bit         sat_flag;
  bit [10:0]  body_count = 11'd1024;
  bit [63:0]  dt_q24 = 64'd8389;
  bit [63:0]  soften = 64'd1;

  in_item_t   pending_beats[$];
  out_item_t  expected_beats[$];
  bit         slot_loaded [MAX_SLOTS];
  int         loaded_slots[$];
  int         fails;

  // --------------------------------------------------------------------------
  // fixed-point predictor
  // --------------------------------------------------------------------------

  function automatic int sat_word(longint v);
    if (v > longint'(32'sh7fff_ffff)) begin
      sat_flag = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (v < -longint'(64'h8000_0000)) begin
      sat_flag = 1'b1;
      return 32'sh8000_0000;
    end
    return int'(v);
  endfunction

  function automatic bit [63:0] add_sat(bit [63:0] a, bit [63:0] b);
    bit [63:0] r;
    r = a + b;
    if (r < a) begin
      sat_flag = 1'b1;
      return '1;
    end
    return r;
  endfunction

  function automatic longint clamp_acc(longint v);
    if (v > longint'(ACC_LIMIT)) begin
      sat_flag = 1'b1;
      return longint'(ACC_LIMIT);
    end
    if (v < -longint'(ACC_LIMIT)) begin
      sat_flag = 1'b1;
      return -longint'(ACC_LIMIT);
    end
    return v;
  endfunction

  // newton iterations on 1/sqrt(a), a = mt / 2^32 in [0.25, 1), result q2.30
  function automatic bit [63:0] inv_sqrt(bit [63:0] mt);
    bit [63:0] y, y2, ay2, t, three;
    three = 64'(THREE_Q30);
    y = mt[31] ? 64'(SEED_HI) : 64'(SEED_LO);
    for (int k = 0; k < RSQRT_ITERS; k++) begin
      y2  = (y * y) >> 30;
      ay2 = (mt * y2) >> 32;
      t   = (ay2 >= three) ? 64'd0 : three - ay2;
      y   = (y * t) >> 31;
      if (y > 64'(Y_MAX)) y = 64'(Y_MAX);
    end
    return y;
  endfunction

  function automatic longint pair_force(longint d, bit [63:0] y3, int sh);
    bit [63:0] mag, p;
    mag = (d < 0) ? -d : d;
    p = mag * y3;
    if (sh >= 63) begin
      p = '0;
    end else if (sh >= 0) begin
      p = p >> sh;
    end else if (p > (ACC_LIMIT >> (-sh))) begin
      sat_flag = 1'b1;
      p = ACC_LIMIT;
    end else begin
      p = p << (-sh);
    end
    if (p > ACC_LIMIT) begin
      sat_flag = 1'b1;
      p = ACC_LIMIT;
    end
    return (d < 0) ? -longint'(p) : longint'(p);
  endfunction

  // sign(a) * floor(|a| * dt), split to stay within 64 bits
  function automatic longint scale_dt(longint a);
    bit [63:0] mag, lo, q;
    mag = (a < 0) ? -a : a;
    lo  = {40'd0, mag[DT_BITS-1:0]};
    q   = (mag >> DT_BITS) * dt_q24 + ((lo * dt_q24) >> DT_BITS);
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void gravity_step();
    int        n, s, sh;
    longint    acc [3];
    longint    d [3];
    bit [63:0] d2, m, y, y3, mag;
    n = (body_count > MAX_SLOTS) ? MAX_SLOTS : int'(body_count);
    sat_flag = 1'b0;
    // velocities first, all from the positions before the step
    for (int i = 0; i < n; i++) begin
      for (int c = 0; c < 3; c++) acc[c] = 0;
      for (int j = 0; j < n; j++) begin
        if (j == i) continue;
        d2 = '0;
        for (int c = 0; c < 3; c++) begin
          d[c] = longint'(pos_m[c][j]) - longint'(pos_m[c][i]);
          mag  = (d[c] < 0) ? -d[c] : d[c];
          d2   = add_sat(d2, mag * mag);
        end
        d2 = add_sat(d2, soften);
        // coincident bodies with no softening contribute nothing
        if (d2 == 0) continue;
        m = d2;
        s = 0;
        while (m < (64'd1 << 62)) begin
          m = m << 2;
          s += 2;
        end
        y  = inv_sqrt(m >> 32);
        y3 = (((y * y) >> 30) * y) >> 32;
        sh = 28 + 3 * ((64 - s) / 2 - FRAC_BITS);
        for (int c = 0; c < 3; c++) acc[c] = clamp_acc(acc[c] + pair_force(d[c], y3, sh));
      end
      for (int c = 0; c < 3; c++)
        vel_m[c][i] = sat_word(longint'(vel_m[c][i]) + scale_dt(acc[c]));
    end
    // then drift with the new velocities
    for (int i = 0; i < n; i++)
      for (int c = 0; c < 3; c++)
        pos_m[c][i] = sat_word(longint'(pos_m[c][i]) + scale_dt(vel_m[c][i]));
  endfunction

  // works out the result of one accepted beat and queues it
  function automatic void predict_result(in_item_t it);
    out_item_t r;
    r = '0;
    case (action_e'(it.action))
      ACT_LOAD: begin
        pos_m[0][it.index] = it.in_pos_x;
        pos_m[1][it.index] = it.in_pos_y;
        pos_m[2][it.index] = it.in_pos_z;
        vel_m[0][it.index] = it.in_vel_x;
        vel_m[1][it.index] = it.in_vel_y;
        vel_m[2][it.index] = it.in_vel_z;
        r.kind = KIND_LOAD_ACK;
        r.out_index = it.index;
      end
      ACT_STEP: begin
        gravity_step();
        r.kind = KIND_STEP_DONE;
      end
      ACT_READ: begin
        r.kind = KIND_DATA;
        r.out_index = it.index;
        r.out_pos_x = pos_m[0][it.index];
        r.out_pos_y = pos_m[1][it.index];
        r.out_pos_z = pos_m[2][it.index];
        r.out_vel_x = vel_m[0][it.index];
        r.out_vel_y = vel_m[1][it.index];
        r.out_vel_z = vel_m[2][it.index];
      end
      default: return;   // unused action: silently dropped
    endcase
    r.saturated = sat_flag;
    expected_beats.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // idle pattern: mostly short gaps, a few long ones, and calm stretches
  // --------------------------------------------------------------------------

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // driver: feeds pending beats, holds the payload while stalled
  // --------------------------------------------------------------------------

  int send_gap;
  bit send_calm;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_result(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_data_i  <= pending_beats.pop_front();
          in_valid_i <= 1'b1;
          send_gap = pick_gap(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: random back-pressure, each result beat checked in order
  // --------------------------------------------------------------------------

  int stall_left;
  bit recv_calm;

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: %p", out_data_o);
          fails++;
        end else begin
          e = expected_beats.pop_front();
          check_field("kind", 32'(e.kind), 32'(out_data_o.kind));
          check_field("out_index", 32'(e.out_index), 32'(out_data_o.out_index));
          check_field("out_pos_x", e.out_pos_x, out_data_o.out_pos_x);
          check_field("out_pos_y", e.out_pos_y, out_data_o.out_pos_y);
          check_field("out_pos_z", e.out_pos_z, out_data_o.out_pos_z);
          check_field("out_vel_x", e.out_vel_x, out_data_o.out_vel_x);
          check_field("out_vel_y", e.out_vel_y, out_data_o.out_vel_y);
          check_field("out_vel_z", e.out_vel_z, out_data_o.out_vel_z);
          check_field("saturated", 32'(e.saturated), 32'(out_data_o.saturated));
        end
      end
      if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = pick_gap(recv_calm);
        out_stall_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // near bodies sit within about one unit of the origin, far ones anywhere
  function automatic logic [31:0] rand_coord(bit near);
    if (near) return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    return $urandom;
  endfunction

  task automatic push_load(int slot, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
    in_item_t it;
    it = '0;
    it.action = ACT_LOAD;
    it.index = slot[9:0];
    it.in_pos_x = px;
    it.in_pos_y = py;
    it.in_pos_z = pz;
    it.in_vel_x = vx;
    it.in_vel_y = vy;
    it.in_vel_z = vz;
    pending_beats.push_back(it);
    if (!slot_loaded[slot]) loaded_slots.push_back(slot);
    slot_loaded[slot] = 1'b1;
  endtask

  task automatic push_random_load(int slot, bit near);
    push_load(slot, rand_coord(near), rand_coord(near), rand_coord(near),
              near ? rand_coord(1'b1) >>> 4 : $urandom,
              near ? rand_coord(1'b1) >>> 4 : $urandom,
              near ? rand_coord(1'b1) >>> 4 : $urandom);
  endtask

  // garbage in the payload of step, read and unused beats is don't care
  task automatic push_cmd(action_e act, int slot);
    in_item_t it;
    it.in_pos_x = $urandom;
    it.in_pos_y = $urandom;
    it.in_pos_z = $urandom;
    it.in_vel_x = $urandom;
    it.in_vel_y = $urandom;
    it.in_vel_z = $urandom;
    it.action = act;
    it.index = slot[9:0];
    pending_beats.push_back(it);
  endtask

  // only between phases: everything sent and answered, then a margin
  task automatic drain();
    do @(posedge clk_i);
    while (pending_beats.size() > 0 || in_valid_i || expected_beats.size() > 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      CFG_COUNT: body_count = value[10:0];
      CFG_DT:    dt_q24 = {40'd0, value[23:0]};
      default:   soften = {32'd0, value};
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------

  initial begin
    int n, r;
    logic [31:0] v;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extreme bodies, read back, the index top end, an unused action
    push_load(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_load(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_load(2, '0, '0, '0, '0, '0, '0);
    push_load(3, '0, '0, '0, 32'h0000_0001, 32'hffff_ffff, '0);
    push_load(1023, 32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f,
              32'hf0f0_f0f0, 32'h3333_3333, 32'hcccc_cccc);
    push_cmd(ACT_READ, 0);
    push_cmd(ACT_READ, 1);
    push_cmd(ACT_READ, 1023);
    push_cmd(ACT_NONE, 5);
    drain();

    // empty step: nothing moves, flag cleared
    write_reg(CFG_COUNT, 32'd0);
    push_cmd(ACT_STEP, 0);
    push_cmd(ACT_READ, 2);
    drain();

    // coincident pair with no softening, extreme pair far apart, dt at max
    write_reg(CFG_COUNT, 32'd4);
    write_reg(CFG_DT, 32'h00ff_ffff);
    write_reg(CFG_SOFT, 32'd0);
    push_cmd(ACT_STEP, 0);
    for (int i = 0; i < 4; i++) push_cmd(ACT_READ, i);
    drain();

    // two bodies one lsb apart: force clamps, velocity saturates
    write_reg(CFG_COUNT, 32'd2);
    push_load(0, '0, '0, '0, '0, '0, '0);
    push_load(1, 32'd1, '0, '0, '0, '0, '0);
    push_cmd(ACT_STEP, 0);
    push_cmd(ACT_READ, 1);
    drain();

    // widest softening, zero time step
    write_reg(CFG_SOFT, 32'hffff_ffff);
    write_reg(CFG_DT, 32'd0);
    push_cmd(ACT_STEP, 0);
    push_cmd(ACT_READ, 0);
    drain();

    // counts at and above the store size: loads and reads only, no step
    write_reg(CFG_COUNT, 32'd2047);
    push_random_load(1022, 1'b0);
    push_cmd(ACT_READ, 1022);
    drain();
    write_reg(CFG_COUNT, 32'd1024);
    push_cmd(ACT_READ, 1023);
    drain();

    // random phases: fresh settings, a well-formed cluster, then a mix of beats
    for (int ph = 0; ph < 6; ph++) begin
      r = $urandom_range(0, 9);
      n = (ph == 0) ? 1 : (r < 7) ? $urandom_range(2, 8) :
          (r < 9) ? $urandom_range(9, 16) : 24;
      write_reg(CFG_COUNT, n);
      r = $urandom_range(0, 3);
      v = (r == 0) ? 32'd0 : (r == 1) ? 32'h00ff_ffff : (r == 2) ? 32'd8389 : $urandom;
      write_reg(CFG_DT, v);
      r = $urandom_range(0, 3);
      v = (r == 0) ? 32'd0 : (r == 1) ? 32'hffff_ffff :
          (r == 2) ? 32'($urandom_range(0, 255)) : $urandom;
      write_reg(CFG_SOFT, v);

      for (int i = 0; i < n; i++) push_random_load(i, $urandom_range(0, 9) < 8);
      for (int k = 0; k < 7; k++) begin
        r = $urandom_range(0, 99);
        if (r < 38) begin
          push_cmd(ACT_READ, loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
        end else if (r < 63) begin
          push_cmd(ACT_STEP, $urandom_range(0, 1023));
        end else if (r < 80) begin
          push_random_load($urandom_range(0, n - 1), 1'b1);
        end else if (r < 96) begin
          push_random_load($urandom_range(0, 1023), $urandom_range(0, 1));
        end else begin
          push_cmd(ACT_NONE, $urandom_range(0, 1023));
        end
      end
      drain();
    end

    if (fails == 0) begin
      $display("** nbody_gravity_step_core: PASSED **");
    end else begin
      $display("** nbody_gravity_step_core: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("** nbody_gravity_step_core: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
src/nbs_pkg.sv
src/nbs_ram.sv
src/nbs_mul.sv
src/nbody_gravity_step_core.sv
verif/tb_nbody_gravity_step_core.sv
